// ===== rtl/sha512_stream_hasher_core_macros.svh =====
// ---------------------------------------------------------------------------
// sha512 stream hasher assertion macros
// concurrent check wrappers, empty when SYNTH is set
// ---------------------------------------------------------------------------
`ifndef SHA512_STREAM_HASHER_CORE_MACROS_SVH
`define SHA512_STREAM_HASHER_CORE_MACROS_SVH
`ifndef SYNTH
// plain property checked at every rising clock edge outside reset
`define S512_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("s512 check failed");
// same-cycle implication
`define S512_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("s512 implication failed");
// next-cycle implication
`define S512_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("s512 next-cycle check failed");
`else
`define S512_ASSERT(label, clk, rst, prop)
`define S512_ASSERT_IMPL(label, clk, rst, pre, post)
`define S512_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== rtl/s512_pkg.sv =====
// ---------------------------------------------------------------------------
// s512_pkg
// shared types, constants and the round constant table for the sha-512 core
// ---------------------------------------------------------------------------
`default_nettype none

package s512_pkg;

   localparam int unsigned WORD_W   = 64;
   localparam int unsigned ROUNDS   = 80;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   // eight 64-bit words, index 0 is a / H0
   typedef logic [7:0][WORD_W-1:0] state_type;

   // result of one round of the shared unit
   typedef struct packed {
      state_type         vars;
      logic [WORD_W-1:0] sched;
   } round_out_type;

   localparam state_type INIT_H = {
      64'h5BE0CD19137E2179, 64'h1F83D9ABFB41BD6B,
      64'h9B05688C2B3E6C1F, 64'h510E527FADE682D1,
      64'hA54FF53A5F1D36F1, 64'h3C6EF372FE94F82B,
      64'hBB67AE8584CAA73B, 64'h6A09E667F3BCC908
   };

   function automatic logic [WORD_W-1:0] rotr(logic [WORD_W-1:0] x, int unsigned n);
      return (x >> n) | (x << (WORD_W - n));
   endfunction

   function automatic logic [WORD_W-1:0] round_k(logic [6:0] t);
      logic [WORD_W-1:0] k;
      unique case (t)
         7'd0:  k = 64'h428A2F98D728AE22;
         7'd1:  k = 64'h7137449123EF65CD;
         7'd2:  k = 64'hB5C0FBCFEC4D3B2F;
         7'd3:  k = 64'hE9B5DBA58189DBBC;
         7'd4:  k = 64'h3956C25BF348B538;
         7'd5:  k = 64'h59F111F1B605D019;
         7'd6:  k = 64'h923F82A4AF194F9B;
         7'd7:  k = 64'hAB1C5ED5DA6D8118;
         7'd8:  k = 64'hD807AA98A3030242;
         7'd9:  k = 64'h12835B0145706FBE;
         7'd10: k = 64'h243185BE4EE4B28C;
         7'd11: k = 64'h550C7DC3D5FFB4E2;
         7'd12: k = 64'h72BE5D74F27B896F;
         7'd13: k = 64'h80DEB1FE3B1696B1;
         7'd14: k = 64'h9BDC06A725C71235;
         7'd15: k = 64'hC19BF174CF692694;
         7'd16: k = 64'hE49B69C19EF14AD2;
         7'd17: k = 64'hEFBE4786384F25E3;
         7'd18: k = 64'h0FC19DC68B8CD5B5;
         7'd19: k = 64'h240CA1CC77AC9C65;
         7'd20: k = 64'h2DE92C6F592B0275;
         7'd21: k = 64'h4A7484AA6EA6E483;
         7'd22: k = 64'h5CB0A9DCBD41FBD4;
         7'd23: k = 64'h76F988DA831153B5;
         7'd24: k = 64'h983E5152EE66DFAB;
         7'd25: k = 64'hA831C66D2DB43210;
         7'd26: k = 64'hB00327C898FB213F;
         7'd27: k = 64'hBF597FC7BEEF0EE4;
         7'd28: k = 64'hC6E00BF33DA88FC2;
         7'd29: k = 64'hD5A79147930AA725;
         7'd30: k = 64'h06CA6351E003826F;
         7'd31: k = 64'h142929670A0E6E70;
         7'd32: k = 64'h27B70A8546D22FFC;
         7'd33: k = 64'h2E1B21385C26C926;
         7'd34: k = 64'h4D2C6DFC5AC42AED;
         7'd35: k = 64'h53380D139D95B3DF;
         7'd36: k = 64'h650A73548BAF63DE;
         7'd37: k = 64'h766A0ABB3C77B2A8;
         7'd38: k = 64'h81C2C92E47EDAEE6;
         7'd39: k = 64'h92722C851482353B;
         7'd40: k = 64'hA2BFE8A14CF10364;
         7'd41: k = 64'hA81A664BBC423001;
         7'd42: k = 64'hC24B8B70D0F89791;
         7'd43: k = 64'hC76C51A30654BE30;
         7'd44: k = 64'hD192E819D6EF5218;
         7'd45: k = 64'hD69906245565A910;
         7'd46: k = 64'hF40E35855771202A;
         7'd47: k = 64'h106AA07032BBD1B8;
         7'd48: k = 64'h19A4C116B8D2D0C8;
         7'd49: k = 64'h1E376C085141AB53;
         7'd50: k = 64'h2748774CDF8EEB99;
         7'd51: k = 64'h34B0BCB5E19B48A8;
         7'd52: k = 64'h391C0CB3C5C95A63;
         7'd53: k = 64'h4ED8AA4AE3418ACB;
         7'd54: k = 64'h5B9CCA4F7763E373;
         7'd55: k = 64'h682E6FF3D6B2B8A3;
         7'd56: k = 64'h748F82EE5DEFB2FC;
         7'd57: k = 64'h78A5636F43172F60;
         7'd58: k = 64'h84C87814A1F0AB72;
         7'd59: k = 64'h8CC702081A6439EC;
         7'd60: k = 64'h90BEFFFA23631E28;
         7'd61: k = 64'hA4506CEBDE82BDE9;
         7'd62: k = 64'hBEF9A3F7B2C67915;
         7'd63: k = 64'hC67178F2E372532B;
         7'd64: k = 64'hCA273ECEEA26619C;
         7'd65: k = 64'hD186B8C721C0C207;
         7'd66: k = 64'hEADA7DD6CDE0EB1E;
         7'd67: k = 64'hF57D4F7FEE6ED178;
         7'd68: k = 64'h06F067AA72176FBA;
         7'd69: k = 64'h0A637DC5A2C898A6;
         7'd70: k = 64'h113F9804BEF90DAE;
         7'd71: k = 64'h1B710B35131C471B;
         7'd72: k = 64'h28DB77F523047D84;
         7'd73: k = 64'h32CAAB7B40C72493;
         7'd74: k = 64'h3C9EBE0A15C9BEBC;
         7'd75: k = 64'h431D67C49C100D4C;
         7'd76: k = 64'h4CC5D4BECB3E42B6;
         7'd77: k = 64'h597F299CFC657E2A;
         7'd78: k = 64'h5FCB6FAB3AD6FAEC;
         7'd79: k = 64'h6C44198C4A475817;
         default: k = '0;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/s512_round.sv =====
// ---------------------------------------------------------------------------
// s512_round
// one sha-512 compression round plus the next message schedule word
// ---------------------------------------------------------------------------
`default_nettype none

module s512_round (
   input  s512_pkg::state_type     vars,
   input  logic [63:0]             w0,
   input  logic [63:0]             w1,
   input  logic [63:0]             w9,
   input  logic [63:0]             w14,
   input  logic [63:0]             k,
   output s512_pkg::round_out_type result
);

   logic [63:0] sig0, sig1, sum0, sum1, ch, maj, t0, t1;

   always_comb begin
      // schedule word for round t+16
      sig0 = s512_pkg::rotr(w1, 1) ^ s512_pkg::rotr(w1, 8) ^ (w1 >> 7);
      sig1 = s512_pkg::rotr(w14, 19) ^ s512_pkg::rotr(w14, 61) ^ (w14 >> 6);
      result.sched = sig1 + w9 + sig0 + w0;

      sum1 = s512_pkg::rotr(vars[4], 14) ^ s512_pkg::rotr(vars[4], 18)
           ^ s512_pkg::rotr(vars[4], 41);
      sum0 = s512_pkg::rotr(vars[0], 28) ^ s512_pkg::rotr(vars[0], 34)
           ^ s512_pkg::rotr(vars[0], 39);
      ch   = vars[6] ^ (vars[4] & (vars[5] ^ vars[6]));
      maj  = (vars[0] & vars[1]) | ((vars[0] | vars[1]) & vars[2]);
      t0   = vars[7] + sum1 + ch + k + w0;
      t1   = sum0 + maj;

      result.vars[7] = vars[6];
      result.vars[6] = vars[5];
      result.vars[5] = vars[4];
      result.vars[4] = vars[3] + t0;
      result.vars[3] = vars[2];
      result.vars[2] = vars[1];
      result.vars[1] = vars[0];
      result.vars[0] = t0 + t1;
   end

endmodule

`default_nettype wire

// ===== rtl/sha512_stream_hasher_core.sv =====
// ---------------------------------------------------------------------------
// sha512_stream_hasher_core
// sha-512 over a stream of big-endian 64-bit words, eight digest transfers
// per message
// ---------------------------------------------------------------------------
//
//  channel | direction | tdata fields (low bit up)          | tuser/tlast
//  req     | in        | msg_word[63:0], byte_count[67:64]  | tlast = last
//  rsp     | out       | digest_word[63:0], word_index[66:64] | tlast = digest_last
//
//  a non-final word is taken in the idle state; every 16th word starts a
//  compression (80 rounds on the shared round unit, one fold)
//  the final word is followed by one pad word a cycle (held while a block is
//  compressed), one or two compressions, then eight rsp transfers; req_tready
//  is low throughout; sustained rate is set by the one-round-per-cycle loop
//  synchronous active-high reset restores the initial hash values
//  a stalled rsp holds the digest word; no new message starts until all
//  eight transfers are done
//
`default_nettype none
`include "sha512_stream_hasher_core_macros.svh"

module sha512_stream_hasher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // msg_word[63:0], byte_count[67:64], zero fill
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // digest_word[63:0], word_index[66:64], zero fill
   output logic        rsp_tlast
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_ROUND = 5'b00010,
      S_FOLD  = 5'b00100,
      S_PAD   = 5'b01000,
      S_OUT   = 5'b10000
   } state_enum_type;

   state_enum_type state_ff, state_in;

   s512_pkg::state_type   hash_ff, hash_in;   // chaining value
   s512_pkg::state_type   vars_ff, vars_in;   // working variables a..h
   logic [15:0][63:0]     win_ff, win_in;     // message schedule window
   logic [3:0]            pos_ff, pos_in;     // words held in the block
   logic [63:0]           blen_ff, blen_in;   // message length in bits
   logic [6:0]            round_ff, round_in;
   logic [2:0]            idx_ff, idx_in;     // digest word being sent
   logic                  pad_ff, pad_in;     // message closed, padding
   logic                  mark_ff, mark_in;   // pad byte still owed
   logic                  lenok_ff, lenok_in; // length fits this block
   logic                  done_ff, done_in;   // length word pushed

   logic [63:0]           msg_word;
   logic [3:0]            byte_count;
   logic [3:0]            n_sat;
   logic [63:0]           padded;
   logic                  req_xfer, rsp_xfer;
   logic                  push;
   logic [63:0]           push_word;
   s512_pkg::round_out_type rnd;

   assign msg_word   = req_tdata[63:0];
   assign byte_count = req_tdata[67:64];
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {5'b0, idx_ff, hash_ff[idx_ff]};
   assign rsp_tlast  = (idx_ff == 3'd7);

   // byte count above eight counts as eight
   assign n_sat = (byte_count > 4'd8) ? 4'd8 : byte_count;

   // keep the leading bytes, pad byte right after them, zeros beyond
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         if (4'(b) < n_sat) begin
            padded[63 - 8*b -: 8] = msg_word[63 - 8*b -: 8];
         end else if (4'(b) == n_sat) begin
            padded[63 - 8*b -: 8] = s512_pkg::PAD_BYTE;
         end else begin
            padded[63 - 8*b -: 8] = 8'h00;
         end
      end
   end

   s512_round u_round (
      .vars   (vars_ff),
      .w0     (win_ff[0]),
      .w1     (win_ff[1]),
      .w9     (win_ff[9]),
      .w14    (win_ff[14]),
      .k      (s512_pkg::round_k(round_ff)),
      .result (rnd)
   );

   always_comb begin
      state_in = state_ff;
      hash_in  = hash_ff;
      vars_in  = vars_ff;
      win_in   = win_ff;
      pos_in   = pos_ff;
      blen_in  = blen_ff;
      round_in = round_ff;
      idx_in   = idx_ff;
      pad_in   = pad_ff;
      mark_in  = mark_ff;
      lenok_in = lenok_ff;
      done_in  = done_ff;
      push      = 1'b0;
      push_word = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               push = 1'b1;
               if (req_tlast) begin
                  push_word = padded;
                  blen_in   = blen_ff + {57'd0, n_sat, 3'b000};
                  pad_in    = 1'b1;
                  // padding follows, after a compression if this word fills the block
                  state_in  = S_PAD;
                  if (n_sat == 4'd8) begin
                     mark_in = 1'b1;
                  end else begin
                     lenok_in = (pos_ff != 4'd14);
                  end
               end else begin
                  push_word = msg_word;
                  blen_in   = blen_ff + 64'd64;
               end
            end
         end
         S_PAD: begin
            push = 1'b1;
            priority if (mark_ff) begin
               push_word = {s512_pkg::PAD_BYTE, 56'd0};
               mark_in   = 1'b0;
               lenok_in  = (pos_ff != 4'd14);
            end else if (pos_ff == 4'd15 && lenok_ff) begin
               push_word = blen_ff;
               done_in   = 1'b1;
            end else begin
               push_word = '0;
               // extra block: the length goes into the next one
               if (pos_ff == 4'd15) begin
                  lenok_in = 1'b1;
               end
            end
         end
         S_ROUND: begin
            vars_in  = rnd.vars;
            win_in   = {rnd.sched, win_ff[15:1]};
            round_in = round_ff + 7'd1;
            if (round_ff == 7'(s512_pkg::ROUNDS - 1)) begin
               round_in = '0;
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + vars_ff[i];
            end
            priority if (done_ff) begin
               state_in = S_OUT;
            end else if (pad_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            if (rsp_xfer) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  hash_in  = s512_pkg::INIT_H;
                  blen_in  = '0;
                  pad_in   = 1'b0;
                  mark_in  = 1'b0;
                  lenok_in = 1'b0;
                  done_in  = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // shift a word into the window; a full block starts the rounds
      if (push) begin
         win_in = {push_word, win_ff[15:1]};
         pos_in = pos_ff + 4'd1;
         if (pos_ff == 4'd15) begin
            vars_in  = hash_ff;
            round_in = '0;
            state_in = S_ROUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hash_ff  <= s512_pkg::INIT_H;
         pos_ff   <= '0;
         blen_ff  <= '0;
         round_ff <= '0;
         idx_ff   <= '0;
         pad_ff   <= 1'b0;
         mark_ff  <= 1'b0;
         lenok_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         hash_ff  <= hash_in;
         pos_ff   <= pos_in;
         blen_ff  <= blen_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         pad_ff   <= pad_in;
         mark_ff  <= mark_in;
         lenok_ff <= lenok_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      vars_ff <= vars_in;
      win_ff  <= win_in;
   end

   // never take a word while a digest is on offer
   `S512_ASSERT(a_no_overlap, clock, reset, !(req_tready && rsp_tvalid))
   // the round counter stays inside the schedule
   `S512_ASSERT_IMPL(a_round_range, clock, reset, state_ff == S_ROUND, round_ff < 7'd80)
   // the final fold hands straight over to the digest output
   `S512_ASSERT_NEXT(a_fold_to_out, clock, reset, state_ff == S_FOLD && done_ff,
                     state_ff == S_OUT)
   // digest output only with an empty block
   `S512_ASSERT_IMPL(a_out_empty, clock, reset, state_ff == S_OUT, pos_ff == 4'd0)
   // last digest transfer returns to a fresh message
   `S512_ASSERT_NEXT(a_restart, clock, reset, rsp_xfer && rsp_tlast,
                     state_ff == S_IDLE && blen_ff == 64'd0 && !pad_ff)

endmodule

`default_nettype wire
